FILE: rtl/spq_pkg.sv
package spq_pkg;

	// default depth of the cell row
	localparam int DEF_CAPACITY = 16;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;

	// opcodes of an input word
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes of a result word
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// one stored entry
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t entry;
	} cmd_t;

endpackage

FILE: rtl/spq_cell.sv
module spq_cell import spq_pkg::*; #(
	parameter int CW    = 5,
	parameter int INDEX = 0
) (
	input  logic          clk,
	input  cmd_t          cmd,
	input  logic [CW-1:0] count,
	input  entry_t        left_data,
	input  logic          left_place,
	input  entry_t        right_data,
	output entry_t        data,
	output logic          place
);

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	entry_t data_q;

	// this slot lies at or after the insert point: it is the free tail slot
	// or holds a strictly larger priority number
	assign place = (IDX <= count) && ((IDX == count) || (data_q.prio > cmd.entry.prio));
	assign data  = data_q;

	// shift right on insert, shift left on remove
	always_ff @(posedge clk) begin
		if (cmd.ins && place) begin
			data_q <= left_place ? left_data : cmd.entry;
		end else if (cmd.rem) begin
			data_q <= right_data;
		end
	end

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// Sorted priority queue built as a row of CAPACITY cells, head in cell 0.
// Lower priority number is served first; equal priorities leave in arrival
// order.
// Command channel: a word (opcode, entry_value, entry_priority) is taken at
// a rising edge with start high and busy low. busy stays low, so a word may
// be issued in every cycle: one item per cycle.
// Result channel: status, removed_value, removed_priority and occupancy are
// valid for the single cycle that done is high, in the cycle after the
// word was taken. The receiver cannot stall, so it must take every result
// in that cycle.
// Each cell compares its priority with the new one in parallel and the row
// shifts right (insert) or left (remove) in the same edge; that parallel
// cell update sets the latency and the rate.
// Reset (arst_n low) empties the queue and clears done; stored entries are
// not cleared and are never read before written.
// Insert on a full queue reports full, remove on an empty queue reports
// empty; neither changes the contents. occupancy is the low five bits of
// the entry count.
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      opcode,
	input  logic signed [VALUE_W-1:0] entry_value,
	input  logic [PRIO_W-1:0]         entry_priority,
	output logic                      done,
	output logic [1:0]                status,
	output logic signed [VALUE_W-1:0] removed_value,
	output logic [PRIO_W-1:0]         removed_priority,
	output logic [4:0]                occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	logic [CW-1:0] count_q;
	logic          full;
	logic          empty;
	logic          take;
	cmd_t          cmd;

	entry_t        data  [CAPACITY];
	logic          place [CAPACITY];

	logic                      done_q;
	logic [1:0]                status_q;
	logic signed [VALUE_W-1:0] rvalue_q;
	logic [PRIO_W-1:0]         rprio_q;
	logic [CW+4:0]             count_wide;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = (count_q == CAP);
	assign empty = (count_q == '0);

	// command decode for the cell row
	assign cmd.ins         = take && (opcode == OP_INSERT) && !full;
	assign cmd.rem         = take && (opcode == OP_REMOVE) && !empty;
	assign cmd.entry.value = entry_value;
	assign cmd.entry.prio  = entry_priority;

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t ldata;
		logic   lplace;
		entry_t rdata;

		if (i == 0) begin : g_head
			assign ldata  = cmd.entry;
			assign lplace = 1'b0;
		end else begin : g_mid
			assign ldata  = data[i-1];
			assign lplace = place[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rdata = data[i];
		end else begin : g_body
			assign rdata = data[i+1];
		end

		spq_cell #(
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_data  (ldata),
			.left_place (lplace),
			.right_data (rdata),
			.data       (data[i]),
			.place      (place[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.rem) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= take;
		end
	end

	// result word, head entry captured on remove
	always_ff @(posedge clk) begin
		if (take) begin
			if (opcode == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
				rvalue_q <= '0;
				rprio_q  <= '0;
			end else if (empty) begin
				status_q <= ST_EMPTY;
				rvalue_q <= '0;
				rprio_q  <= '0;
			end else begin
				status_q <= ST_REMOVED;
				rvalue_q <= data[0].value;
				rprio_q  <= data[0].prio;
			end
		end
	end

	assign count_wide       = {5'b0, count_q};
	assign done             = done_q;
	assign status           = status_q;
	assign removed_value    = rvalue_q;
	assign removed_priority = rprio_q;
	assign occupancy        = count_wide[4:0];

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("entry count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("accepted word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> !done)
		else $error("result without an accepted word");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (opcode == OP_INSERT) && full) |=> $stable(count_q))
		else $error("insert on full queue changed the count");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_REMOVED))
			|-> ((removed_value == 0) && (removed_priority == 0)))
		else $error("payload nonzero on a non-remove result");

endmodule

FILE: dv/tb.sv
module tb;
	import spq_pkg::*;

	localparam int CAP   = DEF_CAPACITY;
	localparam int LIMIT = 200000;

	// one expected result word
	typedef struct {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
		logic [4:0]                occ;
	} result_t;

	// sorted copy of the queue, expected result words and mismatch count
	class order_tracker;
		logic signed [VALUE_W-1:0] slot_value [CAP];
		logic [PRIO_W-1:0]         slot_prio  [CAP];
		int                        stored;
		result_t                   pending_results [$];
		int                        errors;
		int                        n_words, n_ins, n_rem, n_full, n_empty;

		function new();
			stored  = 0;
			errors  = 0;
			n_words = 0;
			n_ins   = 0;
			n_rem   = 0;
			n_full  = 0;
			n_empty = 0;
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("tb: mismatch at %0t: %s", $realtime, what);
		endtask

		// update the sorted copy with one word and return its result
		function result_t apply_word(logic op, logic signed [VALUE_W-1:0] val,
			logic [PRIO_W-1:0] pri);
			result_t r;
			int      pos;
			r.value = '0;
			r.prio  = '0;
			if (op == OP_INSERT) begin
				if (stored >= CAP) begin
					r.status = ST_FULL;
				end else begin
					// behind every entry of equal or lower number
					pos = stored;
					for (int i = 0; i < stored; i++)
						if (slot_prio[i] > pri && pos == stored)
							pos = i;
					for (int i = stored; i > pos; i--) begin
						slot_value[i] = slot_value[i-1];
						slot_prio[i]  = slot_prio[i-1];
					end
					slot_value[pos] = val;
					slot_prio[pos]  = pri;
					stored++;
					r.status = ST_INSERTED;
				end
			end else begin
				if (stored == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// pop the head and close the gap
					r.value = slot_value[0];
					r.prio  = slot_prio[0];
					for (int i = 1; i < stored; i++) begin
						slot_value[i-1] = slot_value[i];
						slot_prio[i-1]  = slot_prio[i];
					end
					stored--;
					r.status = ST_REMOVED;
				end
			end
			r.occ = 5'(stored);
			return r;
		endfunction

		task take_word(logic op, logic signed [VALUE_W-1:0] val, logic [PRIO_W-1:0] pri);
			result_t r;
			r = apply_word(op, val, pri);
			pending_results.push_back(r);
			n_words++;
			case (r.status)
				ST_INSERTED: n_ins++;
				ST_REMOVED:  n_rem++;
				ST_FULL:     n_full++;
				default:     n_empty++;
			endcase
		endtask

		task check_word(logic [1:0] st, logic signed [VALUE_W-1:0] val,
			logic [PRIO_W-1:0] pri, logic [4:0] occ);
			result_t r;
			if (pending_results.size() == 0) begin
				report("result word with no word pending");
			end else begin
				r = pending_results.pop_front();
				if (st !== r.status)
					report($sformatf("status %0d, expected %0d", st, r.status));
				if (val !== r.value)
					report($sformatf("removed_value %h, expected %h", val, r.value));
				if (pri !== r.prio)
					report($sformatf("removed_priority %h, expected %h", pri, r.prio));
				if (occ !== r.occ)
					report($sformatf("occupancy %0d, expected %0d", occ, r.occ));
			end
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      opcode;
	logic signed [VALUE_W-1:0] entry_value;
	logic [PRIO_W-1:0]         entry_priority;
	logic                      done;
	logic [1:0]                status;
	logic signed [VALUE_W-1:0] removed_value;
	logic [PRIO_W-1:0]         removed_priority;
	logic [4:0]                occupancy;

	order_tracker tracker = new();
	int           idle_pct;
	int           insert_bias;
	int           cycles;

	sorted_priority_queue_core #(
		.CAPACITY(CAP)
	) DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.entry_value     (entry_value),
		.entry_priority  (entry_priority),
		.done            (done),
		.status          (status),
		.removed_value   (removed_value),
		.removed_priority(removed_priority),
		.occupancy       (occupancy)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watch both channels: result word first, then the word taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_word(status, removed_value, removed_priority, occupancy);
			if (start && !busy)
				tracker.take_word(opcode, entry_value, entry_priority);
		end
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// present one word, with random idle cycles ahead of it
	task automatic issue(input logic op, input logic signed [VALUE_W-1:0] val,
		input logic [PRIO_W-1:0] pri);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start          <= 1'b1;
		opcode         <= op;
		entry_value    <= val;
		entry_priority <= pri;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off until every expected result word has come
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// random word: bursts lean toward insert or remove to reach full and empty
	task automatic random_word();
		logic                      op;
		logic signed [VALUE_W-1:0] val;
		logic [PRIO_W-1:0]         pri;
		op = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_REMOVE;
		case ($urandom_range(7))
			0:       val = 32'sh8000_0000;
			1:       val = 32'sh7fff_ffff;
			2:       val = '0;
			3:       val = -1;
			default: val = $urandom;
		endcase
		case ($urandom_range(3))
			0:       pri = 16'($urandom_range(3));
			1:       pri = $urandom_range(1) ? 16'hffff : 16'h0000;
			default: pri = 16'($urandom_range(16'hffff));
		endcase
		issue(op, val, pri);
	endtask

	// stimulus
	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = OP_INSERT;
		entry_value    = '0;
		entry_priority = '0;
		idle_pct       = 12;
		insert_bias    = 50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty remove, extremes, ties in arrival order
		issue(OP_REMOVE, 32'sh1234_5678, 16'h00ff);
		issue(OP_INSERT, 32'sh8000_0000, 16'hffff);
		issue(OP_INSERT, 32'sh7fff_ffff, 16'h0000);
		issue(OP_INSERT, -1, 16'h0000);
		issue(OP_INSERT, '0, 16'hffff);
		issue(OP_INSERT, 12345, 16'h8000);
		issue(OP_INSERT, -777, 16'h0001);
		repeat (6) issue(OP_REMOVE, '0, '0);
		issue(OP_REMOVE, -1, 16'hffff);
		drain();

		// random phases: sender idling 12 percent, then 73, then none
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 12 : (ph == 1) ? 73 : 0;
			for (int n = 0; n < 400; n++) begin
				if (n % 40 == 0)
					case ($urandom_range(2))
						0:       insert_bias = 90;
						1:       insert_bias = 50;
						default: insert_bias = 10;
					endcase
				if ($urandom_range(99) == 0)
					drain();
				random_word();
			end
			drain();
		end

		// wrap up: wait until nothing is pending, then check again before the summary
		start <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.pending_results.size() != 0)
			tracker.report("result words still expected at the end");
		$display("tb: %0d words: %0d inserted, %0d removed, %0d full, %0d empty",
			tracker.n_words, tracker.n_ins, tracker.n_rem, tracker.n_full, tracker.n_empty);
		$display("tb: sender idle at 12, 73 and 0 percent, with drain pauses");
		if (tracker.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
